@@ rtl/core/u16je_pkg.sv @@
// ----------------------------------------------------------------------------
// u16je_pkg
// Shared types, constants and the code point encoder for the UTF-16 to
// JSON-escaped UTF-8 converter.
// ----------------------------------------------------------------------------
package u16je_pkg;

  localparam int MAX_BYTES = 9;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int IDX_W     = $clog2(MAX_BYTES);
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A_OFS  = 8'h57;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  typedef struct packed {
    logic [5:0][7:0] b;
    logic [2:0]      n;
  } enc_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
  } record_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'h0, d};
    end else begin
      r = CH_A_OFS + {4'h0, d};
    end
    return r;
  endfunction

  function automatic enc_t encode_point(input logic [20:0] cp);
    enc_t e;
    e.b = '0;
    e.n = 3'd0;
    if (cp < 21'h20 || cp == {13'd0, CH_QUOTE} || cp == {13'd0, CH_BSLASH}) begin
      e.b[0] = CH_BSLASH;
      if (cp == {13'd0, CH_LF}) begin
        e.b[1] = CH_N;
        e.n    = 3'd2;
      end else if (cp == {13'd0, CH_CR}) begin
        e.b[1] = CH_R;
        e.n    = 3'd2;
      end else if (cp == {13'd0, CH_QUOTE} || cp == {13'd0, CH_BSLASH}) begin
        e.b[1] = cp[7:0];
        e.n    = 3'd2;
      end else begin
        e.b[1] = CH_U;
        e.b[2] = CH_ZERO;
        e.b[3] = CH_ZERO;
        e.b[4] = hex_char(cp[7:4]);
        e.b[5] = hex_char(cp[3:0]);
        e.n    = 3'd6;
      end
    end else if (cp <= 21'h7F) begin
      e.b[0] = cp[7:0];
      e.n    = 3'd1;
    end else if (cp <= 21'h7FF) begin
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
      e.n    = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
      e.n    = 3'd3;
    end else begin
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
      e.n    = 3'd4;
    end
    return e;
  endfunction

endpackage

@@ rtl/core/u16je_in_if.sv @@
// ----------------------------------------------------------------------------
// u16je_in_if
// Input channel: one UTF-16 code unit per beat with an end-of-string mark.
// ----------------------------------------------------------------------------
interface u16je_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

@@ rtl/core/u16je_out_if.sv @@
// ----------------------------------------------------------------------------
// u16je_out_if
// Output channel: one byte of escaped UTF-8 per beat.
// ----------------------------------------------------------------------------
interface u16je_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

@@ rtl/core/u16je_front.sv @@
// ----------------------------------------------------------------------------
// u16je_front
// Accepts code units, pairs surrogates and encodes each unit into a record
// of up to nine escaped UTF-8 bytes.
// ----------------------------------------------------------------------------
module u16je_front import u16je_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  u16je_in_if.sink        unit_in,
  input  logic            full,
  output logic            push,
  output record_t         rec
);

  logic        high_pending;
  logic [15:0] held_high_unit;

  logic        accept;
  logic        is_high;
  logic        is_low;
  logic        pair;
  logic        flush;
  logic        hold_now;
  logic        emit_second;
  logic [20:0] pair_cp;
  logic [20:0] second_cp;
  enc_t        enc_h;
  enc_t        enc_s;

  assign unit_in.ready = !full;
  assign accept        = unit_in.valid && !full;

  always_comb begin
    is_high     = unit_in.code_unit >= HIGH_FIRST && unit_in.code_unit <= HIGH_LAST;
    is_low      = unit_in.code_unit >= LOW_FIRST && unit_in.code_unit <= LOW_LAST;
    pair        = high_pending && is_low;
    flush       = high_pending && !is_low;
    hold_now    = !pair && is_high && !unit_in.last_unit;
    emit_second = !hold_now;
    pair_cp     = SUPP_BASE + {1'b0, held_high_unit[9:0], unit_in.code_unit[9:0]};
    second_cp   = pair ? pair_cp : {5'd0, unit_in.code_unit};
    enc_h       = encode_point({5'd0, held_high_unit});
    enc_s       = encode_point(second_cp);
  end

  always_comb begin
    rec.bytes = '0;
    rec.count = '0;
    if (flush) begin
      rec.bytes = emit_second ? {enc_s.b, enc_h.b[2:0]} : {48'h0, enc_h.b[2:0]};
      rec.count = CNT_W'(3) + (emit_second ? CNT_W'(enc_s.n) : CNT_W'(0));
    end else if (emit_second) begin
      rec.bytes = {24'h0, enc_s.b};
      rec.count = CNT_W'(enc_s.n);
    end
  end

  assign push = accept && rec.count != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_pending   <= 1'b0;
      held_high_unit <= '0;
    end else if (accept) begin
      high_pending <= hold_now;
      if (hold_now) begin
        held_high_unit <= unit_in.code_unit;
      end
    end
  end

endmodule

@@ rtl/core/u16je_queue.sv @@
// ----------------------------------------------------------------------------
// u16je_queue
// Short record queue between the encoder front and the byte serialiser.
// ----------------------------------------------------------------------------
module u16je_queue import u16je_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  record_t push_rec,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output record_t head
);

  record_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic [Q_CNT_W-1:0]   count_next;

  assign full       = count == Q_CNT_W'(Q_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/u16je_back.sv @@
// ----------------------------------------------------------------------------
// u16je_back
// Walks the head record one byte per beat into a registered output stage.
// ----------------------------------------------------------------------------
module u16je_back import u16je_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  record_t    head,
  output logic       pop,
  u16je_out_if.source byte_out
);

  logic [IDX_W-1:0] idx;
  logic             o_valid;
  logic [7:0]       o_byte;
  logic             o_last;

  logic             load;
  logic             at_end;

  assign load   = head_valid && (!o_valid || byte_out.ready);
  assign at_end = idx == IDX_W'(head.count - CNT_W'(1));
  assign pop    = load && at_end;

  assign byte_out.valid    = o_valid;
  assign byte_out.out_byte = o_byte;
  assign byte_out.run_last = o_last;

  always_ff @(posedge clk) begin
    if (load) begin
      o_byte <= head.bytes[idx];
      o_last <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      o_valid <= 1'b0;
    end else begin
      if (load) begin
        o_valid <= 1'b1;
        idx     <= at_end ? '0 : idx + IDX_W'(1);
      end else if (byte_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/utf16_to_utf8_json_escaper_top.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_json_escaper_top
// UTF-16 code units in, JSON-escaped UTF-8 bytes out.
// ----------------------------------------------------------------------------
// One code unit is accepted per cycle while the four-record queue has room;
// each unit is encoded in the cycle it is accepted and yields 0 to 9 bytes.
// Bytes leave one per beat from a registered output stage, so a unit that
// yields n bytes produces n output beats and a held high surrogate produces
// none; the output serialiser sets the sustained rate. With the queue empty
// and the output stage free, an accepted unit's record is registered in the
// queue and its first byte then in the output stage, where it is offered.
// run_last marks the final byte of each queued record.
module utf16_to_utf8_json_escaper_top import u16je_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  u16je_in_if.sink    unit_in,
  u16je_out_if.source byte_out
);

  logic    push;
  logic    q_full;
  logic    pop;
  logic    q_head_valid;
  record_t push_rec;
  record_t q_head;

  u16je_front u_front (
    .clk     (clk),
    .rst     (rst),
    .unit_in (unit_in),
    .full    (q_full),
    .push    (push),
    .rec     (push_rec)
  );

  u16je_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  u16je_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (pop),
    .byte_out   (byte_out)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("record pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_head_valid)
    else $error("record popped from an empty queue");

  a_rec_len: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_rec.count != '0 && push_rec.count <= CNT_W'(MAX_BYTES)))
    else $error("record length out of range");

  a_head_len: assert property (@(posedge clk) disable iff (rst)
    q_head_valid |-> q_head.count != '0)
    else $error("empty record at queue head");

endmodule
